// ----- hw/rtl/fps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants of the minimum falling path sum block.
// ----------------------------------------------------------------------------
package fps_pkg;

   localparam int COST_BITS = 32;

   typedef logic signed [COST_BITS-1:0] cost_type;
   typedef logic signed [COST_BITS:0]   sum_type;

   localparam cost_type COST_MAX = 32'sh7fff_ffff;
   localparam cost_type COST_MIN = 32'sh8000_0000;

   localparam int CSR_BITS = 9;

   // saturate a grown sum into the cost range
   function automatic cost_type sat_cost(input sum_type s);
      cost_type r;
      if (s > sum_type'(COST_MAX)) begin
         r = COST_MAX;
      end else if (s < sum_type'(COST_MIN)) begin
         r = COST_MIN;
      end else begin
         r = s[COST_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/fps_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_cell
// One stage of the previous-row cost line; on a shift it loads a new cost
// when it is the entry stage for the current row width, else its neighbour's.
// ----------------------------------------------------------------------------
module fps_cell #(
   parameter int COL_BITS = 8,
   parameter int INDEX    = 0
) (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic [COL_BITS-1:0]   entry_idx,
   input  fps_pkg::cost_type     new_cost,
   input  fps_pkg::cost_type     prev_cost,
   output fps_pkg::cost_type     cost_q
);
   import fps_pkg::*;

   cost_type cost_ff;
   cost_type cost_in;
   logic     is_entry;

   assign is_entry = (entry_idx == COL_BITS'(INDEX));

   always_comb begin
      cost_in = cost_ff;
      if (shift_en) begin
         cost_in = is_entry ? new_cost : prev_cost;
      end
   end

   always_ff @(posedge clock) begin
      cost_ff <= cost_in;
   end

   assign cost_q = cost_ff;

endmodule

// ----- hw/rtl/fps_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_chain
// Row of cost cells. Costs enter at the cell chosen by the row width and
// leave at the far end exactly one row later.
// ----------------------------------------------------------------------------
module fps_chain #(
   parameter int MAX_COLS = 256,
   parameter int COL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic [COL_BITS-1:0]   entry_idx,
   input  fps_pkg::cost_type     new_cost,
   output fps_pkg::cost_type     tail_cost,
   output fps_pkg::cost_type     next_cost
);
   import fps_pkg::*;

   cost_type cell_q [MAX_COLS];

   for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         fps_cell #(.COL_BITS(COL_BITS), .INDEX(i)) u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .entry_idx (entry_idx),
            .new_cost  (new_cost),
            .prev_cost (new_cost),
            .cost_q    (cell_q[i])
         );
      end else begin : g_body
         fps_cell #(.COL_BITS(COL_BITS), .INDEX(i)) u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .entry_idx (entry_idx),
            .new_cost  (new_cost),
            .prev_cost (cell_q[i-1]),
            .cost_q    (cell_q[i])
         );
      end
   end

   assign tail_cost = cell_q[MAX_COLS-1];

   if (MAX_COLS > 1) begin : g_next
      assign next_cost = cell_q[MAX_COLS-2];
   end else begin : g_next_single
      assign next_cost = cell_q[MAX_COLS-1];
   end

endmodule

// ----- hw/rtl/min_falling_path_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_falling_path_sum
// Streaming minimum falling path sum over a row-major grid.
// ----------------------------------------------------------------------------
// Takes one grid value per clock while no result is stalled, with no gaps
// between rows or grids. The cost of a value comes from a combinational add-min
// unit; the previous row lives in a line of MAX_COLS cost cells shifting once per
// transfer, so its far end always holds the cost of the same column one row up.
// A result stays in the output register until taken; input stalls only while
// such a result waits and rsp_tready is low. A row_width write restarts the grid.
// ----------------------------------------------------------------------------
module min_falling_path_sum #(
   parameter int MAX_COLS   = 256,
   parameter int VALUE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration: row_width
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fps_pkg::CSR_BITS-1:0]        csr_data,
   // grid values
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,  // cell_value
   input  logic                                req_tlast,  // last_cell
   // results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata   // min_path_sum
);
   import fps_pkg::*;

   localparam int COL_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [COL_BITS-1:0] last_idx_ff, last_idx_in;
   logic [COL_BITS-1:0] entry_ff, entry_in;
   logic                first_ff, first_in;
   cost_type            run_min_ff, run_min_in;
   cost_type            left_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   cost_type            rsp_data_ff, rsp_data_in;

   logic                req_xfer;
   logic                csr_xfer;
   logic [31:0]         csr_ext;
   logic [31:0]         width_eff;
   logic                last_col;
   cost_type            tail_cost;
   cost_type            next_cost;
   cost_type            best;
   cost_type            cost;
   cost_type            row_min;
   logic signed [VALUE_BITS-1:0] value;

   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid & csr_ready;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_xfer   = req_tvalid & req_tready;

   assign csr_ext = 32'(csr_data);
   always_comb begin
      priority if (csr_ext == 32'd0) begin
         width_eff = 32'd1;
      end else if (csr_ext > 32'(MAX_COLS)) begin
         width_eff = 32'(MAX_COLS);
      end else begin
         width_eff = csr_ext;
      end
   end

   // add-min unit
   assign value    = req_tdata[VALUE_BITS-1:0];
   assign last_col = (col_ff == last_idx_ff);

   always_comb begin
      best = tail_cost;
      if (col_ff != '0 && left_ff < best) begin
         best = left_ff;
      end
      if (!last_col && next_cost < best) begin
         best = next_cost;
      end
      if (first_ff) begin
         best = '0;
      end
   end

   assign cost    = sat_cost(sum_type'(value) + sum_type'(best));
   assign row_min = (cost < run_min_ff) ? cost : run_min_ff;

   fps_chain #(.MAX_COLS(MAX_COLS), .COL_BITS(COL_BITS)) u_chain (
      .clock     (clock),
      .shift_en  (req_xfer),
      .entry_idx (entry_ff),
      .new_cost  (cost),
      .tail_cost (tail_cost),
      .next_cost (next_cost)
   );

   always_comb begin
      col_in       = col_ff;
      last_idx_in  = last_idx_ff;
      entry_in     = entry_ff;
      first_in     = first_ff;
      run_min_in   = run_min_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (csr_xfer) begin
         last_idx_in = COL_BITS'(width_eff - 32'd1);
         entry_in    = COL_BITS'(32'(MAX_COLS) - width_eff);
         col_in      = '0;
         first_in    = 1'b1;
         run_min_in  = COST_MAX;
      end else if (req_xfer) begin
         if (req_tlast) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = row_min;
            col_in       = '0;
            first_in     = 1'b1;
            run_min_in   = COST_MAX;
         end else if (last_col) begin
            col_in     = '0;
            first_in   = 1'b0;
            run_min_in = COST_MAX;
         end else begin
            col_in     = col_ff + 1'b1;
            run_min_in = row_min;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         last_idx_ff  <= '0;
         entry_ff     <= COL_BITS'(MAX_COLS - 1);
         first_ff     <= 1'b1;
         run_min_ff   <= COST_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         last_idx_ff  <= last_idx_in;
         entry_ff     <= entry_in;
         first_ff     <= first_in;
         run_min_ff   <= run_min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // previous-row cost of the left column, kept after its cell moved on
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         left_ff <= tail_cost;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/fps_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks of the minimum falling path sum block.
// ----------------------------------------------------------------------------
module fps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // every last transfer yields a result next cycle
   a_last_result : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("no result after last transfer");

   // a fresh result only follows a last transfer
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid && !rsp_tready)
      |-> $past(req_tvalid && req_tready && req_tlast))
      else $error("result without last transfer");

   // input is taken whenever the output slot is free
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind min_falling_path_sum fps_checker u_fps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
